@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the velocity moment core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge out of reset
`define LVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// lvm_pkg
// types and constants of the lattice velocity moment core
// ----------------------------------------------------------------------------
`default_nettype none

package lvm_pkg;

    localparam int F_W       = 16;   // distribution value
    localparam int DEN_W     = 17;   // density
    localparam int COORD_W   = 10;   // cell coordinate
    localparam int GRID_W    = 11;   // grid size register
    localparam int VEL_W     = 17;   // velocity, signed
    localparam int NUM_W     = 18;   // numerator magnitude
    localparam int CFG_IDX_W = 2;

    localparam int IN_W  = 168;      // 165 field bits padded to bytes
    localparam int OUT_W = 40;       // 34 field bits padded to bytes

    localparam int MAX_GRID_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 15;

    localparam logic signed [VEL_W-1:0] LID_RST    = 17'sd3277;
    localparam logic        [GRID_W-1:0] GRID_RST  = 11'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LID    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ZERO  = 2'd0,
        MODE_LID   = 2'd1,
        MODE_FAULT = 2'd2,
        MODE_DIV   = 2'd3
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  neg_x;
        logic  neg_y;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/lvm_front.sv @@
// ----------------------------------------------------------------------------
// lvm_front
// cell classification and momentum numerators, first pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_front #(
    parameter int MAX_GRID  = lvm_pkg::MAX_GRID_DEF,
    parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
    localparam int DW       = lvm_pkg::NUM_W + FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_east,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_north,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_west,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_south,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_northeast,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_northwest,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_southwest,
    input  wire logic [lvm_pkg::F_W-1:0]       i_f_southeast,
    input  wire logic [lvm_pkg::DEN_W-1:0]     i_density,
    input  wire logic [lvm_pkg::COORD_W-1:0]   i_cell_x,
    input  wire logic [lvm_pkg::COORD_W-1:0]   i_cell_y,
    input  wire logic [lvm_pkg::GRID_W-1:0]    i_grid_width,
    input  wire logic [lvm_pkg::GRID_W-1:0]    i_grid_height,
    output lvm_pkg::t_ctl                      o_ctl,
    output logic [lvm_pkg::DEN_W-1:0]          o_den,
    output logic [DW-1:0]                      o_dq_x,
    output logic [DW-1:0]                      o_dq_y
);

    localparam int GW = lvm_pkg::GRID_W;
    localparam int NW = lvm_pkg::NUM_W;

    logic [GW-1:0]   w_w, w_h, w_x, w_y;
    logic            w_inside, w_top, w_edge;
    logic [NW-1:0]   w_px, w_mx, w_py, w_my;
    logic [NW:0]     w_dx, w_dy;
    logic [NW-1:0]   w_magx, w_magy;
    lvm_pkg::t_mode  w_mode;

    lvm_pkg::t_ctl              r_ctl, n_ctl;
    logic [lvm_pkg::DEN_W-1:0]  r_den;
    logic [DW-1:0]              r_dq_x, r_dq_y;

    // grid sizes above the build limit are clamped
    always_comb begin
        w_w = (32'(i_grid_width)  > MAX_GRID) ? GW'(MAX_GRID) : i_grid_width;
        w_h = (32'(i_grid_height) > MAX_GRID) ? GW'(MAX_GRID) : i_grid_height;
        w_x = {1'b0, i_cell_x};
        w_y = {1'b0, i_cell_y};
        w_inside = (w_x < w_w) && (w_y < w_h);
        w_top    = (w_y + GW'(1)) == w_h;
        w_edge   = (w_x == '0) || (w_y == '0) || ((w_x + GW'(1)) == w_w);
    end

    always_comb begin
        if (!w_inside || w_edge) begin
            w_mode = lvm_pkg::MODE_ZERO;
        end else if (w_top) begin
            w_mode = lvm_pkg::MODE_LID;
        end else if (i_density == '0) begin
            w_mode = lvm_pkg::MODE_FAULT;
        end else begin
            w_mode = lvm_pkg::MODE_DIV;
        end
    end

    // x: 1,5,8 minus 3,6,7   y: 2,5,6 minus 4,7,8
    always_comb begin
        w_px = NW'(i_f_east)  + NW'(i_f_northeast) + NW'(i_f_southeast);
        w_mx = NW'(i_f_west)  + NW'(i_f_northwest) + NW'(i_f_southwest);
        w_py = NW'(i_f_north) + NW'(i_f_northeast) + NW'(i_f_northwest);
        w_my = NW'(i_f_south) + NW'(i_f_southwest) + NW'(i_f_southeast);
        w_dx = {1'b0, w_px} - {1'b0, w_mx};
        w_dy = {1'b0, w_py} - {1'b0, w_my};
        w_magx = w_dx[NW] ? NW'(~w_dx + 1'b1) : w_dx[NW-1:0];
        w_magy = w_dy[NW] ? NW'(~w_dy + 1'b1) : w_dy[NW-1:0];
        n_ctl.valid = i_valid;
        n_ctl.mode  = w_mode;
        n_ctl.neg_x = w_dx[NW];
        n_ctl.neg_y = w_dy[NW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den       <= i_density;
            r_dq_x      <= {w_magx, FRAC_BITS'(0)};
            r_dq_y      <= {w_magy, FRAC_BITS'(0)};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_den  = r_den;
    assign o_dq_x = r_dq_x;
    assign o_dq_y = r_dq_y;

endmodule

`default_nettype wire

@@ rtl/lvm_div_cell.sv @@
// ----------------------------------------------------------------------------
// lvm_div_cell
// one restoring division step for both velocity lanes
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_div_cell #(
    parameter int DW = lvm_pkg::NUM_W + lvm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire lvm_pkg::t_ctl              i_ctl,
    input  wire logic [lvm_pkg::DEN_W-1:0]  i_den,
    input  wire logic [lvm_pkg::DEN_W-1:0]  i_rem_x,
    input  wire logic [lvm_pkg::DEN_W-1:0]  i_rem_y,
    input  wire logic [DW-1:0]              i_dq_x,
    input  wire logic [DW-1:0]              i_dq_y,
    output lvm_pkg::t_ctl                   o_ctl,
    output logic [lvm_pkg::DEN_W-1:0]       o_den,
    output logic [lvm_pkg::DEN_W-1:0]       o_rem_x,
    output logic [lvm_pkg::DEN_W-1:0]       o_rem_y,
    output logic [DW-1:0]                   o_dq_x,
    output logic [DW-1:0]                   o_dq_y
);

    localparam int RW = lvm_pkg::DEN_W;

    logic [RW:0]   w_tx, w_ty, w_den;
    logic          w_gex, w_gey;
    logic [RW-1:0] n_rem_x, n_rem_y;

    lvm_pkg::t_ctl  r_ctl;
    logic [RW-1:0]  r_den, r_rem_x, r_rem_y;
    logic [DW-1:0]  r_dq_x, r_dq_y;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_den = {1'b0, i_den};
        w_tx  = {i_rem_x, i_dq_x[DW-1]};
        w_ty  = {i_rem_y, i_dq_y[DW-1]};
        w_gex = w_tx >= w_den;
        w_gey = w_ty >= w_den;
        n_rem_x = w_gex ? RW'(w_tx - w_den) : w_tx[RW-1:0];
        n_rem_y = w_gey ? RW'(w_ty - w_den) : w_ty[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den       <= i_den;
            r_rem_x     <= n_rem_x;
            r_rem_y     <= n_rem_y;
            r_dq_x      <= {i_dq_x[DW-2:0], w_gex};
            r_dq_y      <= {i_dq_y[DW-2:0], w_gey};
        end
    end

    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_dq_x  = r_dq_x;
    assign o_dq_y  = r_dq_y;

endmodule

`default_nettype wire

@@ rtl/lattice_velocity_moment_core.sv @@
// registered stages in order: the front stage, the division cells, then the output register
// throughput: one cell per cycle while the skid register is empty, through a chain of NUM_W+FRAC_BITS division cells
// a stalled output holds one result plus one in a skid register, then the chain freezes
// reset (synchronous, i_rst_n low) empties the pipe and loads lid 3277, grid 256 x 256
// ----------------------------------------------------------------------------
// lattice_velocity_moment_core
// D2Q9 lattice Boltzmann macroscopic velocity of one cell per transaction
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lattice_velocity_moment_core #(
    parameter int MAX_GRID  = lvm_pkg::MAX_GRID_DEF,
    parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [lvm_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [lvm_pkg::VEL_W-1:0]         i_cfg_wdata,
    // cell input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // f_east, f_north, f_west, f_south, f_northeast, f_northwest,
    // f_southwest, f_southeast (16 each), density (17), cell_x (10), cell_y (10)
    input  wire logic [lvm_pkg::IN_W-1:0]          i_s_tdata,
    // velocity output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // velocity_x (17), velocity_y (17)
    output logic [lvm_pkg::OUT_W-1:0]              o_m_tdata,
    // divide_fault (1)
    output logic                                   o_m_tuser
);

    localparam int DW  = lvm_pkg::NUM_W + FRAC_BITS;   // dividend and quotient width
    localparam int VW  = lvm_pkg::VEL_W;
    localparam int FW  = lvm_pkg::F_W;
    localparam int CW  = lvm_pkg::COORD_W;
    localparam int DNW = lvm_pkg::DEN_W;

    // configuration registers
    logic signed [VW-1:0]            r_lid;
    logic [lvm_pkg::GRID_W-1:0]      r_grid_width, r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lid         <= lvm_pkg::LID_RST;
            r_grid_width  <= lvm_pkg::GRID_RST;
            r_grid_height <= lvm_pkg::GRID_RST;
        end else if (i_cfg_we) begin
            case (lvm_pkg::t_cfg_idx'(i_cfg_addr))
                lvm_pkg::CFG_LID:    r_lid         <= i_cfg_wdata;
                lvm_pkg::CFG_WIDTH:  r_grid_width  <= i_cfg_wdata[lvm_pkg::GRID_W-1:0];
                lvm_pkg::CFG_HEIGHT: r_grid_height <= i_cfg_wdata[lvm_pkg::GRID_W-1:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // whole chain advances together; only a full skid register stops it
    logic r_skid_valid;
    logic w_en;
    logic w_s_accept;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // chain links: index 0 is the front stage, index DW the last cell
    lvm_pkg::t_ctl     w_ctl   [DW+1];
    logic [DNW-1:0]    w_den   [DW+1];
    logic [DNW-1:0]    w_rem_x [DW+1];
    logic [DNW-1:0]    w_rem_y [DW+1];
    logic [DW-1:0]     w_dq_x  [DW+1];
    logic [DW-1:0]     w_dq_y  [DW+1];

    lvm_front #(
        .MAX_GRID  (MAX_GRID),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_s_accept),
        .i_f_east      (i_s_tdata[0*FW +: FW]),
        .i_f_north     (i_s_tdata[1*FW +: FW]),
        .i_f_west      (i_s_tdata[2*FW +: FW]),
        .i_f_south     (i_s_tdata[3*FW +: FW]),
        .i_f_northeast (i_s_tdata[4*FW +: FW]),
        .i_f_northwest (i_s_tdata[5*FW +: FW]),
        .i_f_southwest (i_s_tdata[6*FW +: FW]),
        .i_f_southeast (i_s_tdata[7*FW +: FW]),
        .i_density     (i_s_tdata[8*FW +: DNW]),
        .i_cell_x      (i_s_tdata[8*FW+DNW +: CW]),
        .i_cell_y      (i_s_tdata[8*FW+DNW+CW +: CW]),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_ctl         (w_ctl[0]),
        .o_den         (w_den[0]),
        .o_dq_x        (w_dq_x[0]),
        .o_dq_y        (w_dq_y[0])
    );

    // partial remainders start empty
    assign w_rem_x[0] = '0;
    assign w_rem_y[0] = '0;

    // one quotient bit per cell, most significant first
    for (genvar g = 0; g < DW; g++) begin : g_cell
        lvm_div_cell #(
            .DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_den   (w_den[g]),
            .i_rem_x (w_rem_x[g]),
            .i_rem_y (w_rem_y[g]),
            .i_dq_x  (w_dq_x[g]),
            .i_dq_y  (w_dq_y[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_den   (w_den[g+1]),
            .o_rem_x (w_rem_x[g+1]),
            .o_rem_y (w_rem_y[g+1]),
            .o_dq_x  (w_dq_x[g+1]),
            .o_dq_y  (w_dq_y[g+1])
        );
    end

    // sign and saturation on the finished quotients
    lvm_pkg::t_ctl         w_last;
    logic [DW-1:0]         w_qx, w_qy;
    logic signed [VW-1:0]  w_satx, w_saty;
    logic signed [VW-1:0]  n_vx, n_vy;
    logic                  n_fault;
    logic                  w_new;

    assign w_last = w_ctl[DW];
    assign w_qx   = w_dq_x[DW];
    assign w_qy   = w_dq_y[DW];
    assign w_new  = w_last.valid && w_en;

    function automatic logic [VW-1:0] sat_q(input logic neg, input logic [DW-1:0] q);
        logic hi_pos, hi_neg;
        hi_pos = |q[DW-1:VW-1];
        hi_neg = (|q[DW-1:VW]) || (q[VW-1] && (|q[VW-2:0]));
        if (neg) begin
            sat_q = hi_neg ? {1'b1, {(VW-1){1'b0}}} : VW'(~q[VW-1:0] + 1'b1);
        end else begin
            sat_q = hi_pos ? {1'b0, {(VW-1){1'b1}}} : q[VW-1:0];
        end
    endfunction

    always_comb begin
        w_satx = sat_q(w_last.neg_x, w_qx);
        w_saty = sat_q(w_last.neg_y, w_qy);
        n_vx    = '0;
        n_vy    = '0;
        n_fault = 1'b0;
        case (w_last.mode)
            lvm_pkg::MODE_LID:   n_vx = r_lid;
            lvm_pkg::MODE_FAULT: n_fault = 1'b1;
            lvm_pkg::MODE_DIV: begin
                n_vx = w_satx;
                n_vy = w_saty;
            end
            default: ;   // boundary or outside the grid
        endcase
    end

    // output register with skid register behind it
    logic                  r_out_valid;
    logic signed [VW-1:0]  r_out_vx, r_out_vy, r_skid_vx, r_skid_vy;
    logic                  r_out_fault, r_skid_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid  <= r_skid_valid || w_new;
            r_skid_valid <= 1'b0;
        end else if (w_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_vx    <= r_skid_vx;
                r_out_vy    <= r_skid_vy;
                r_out_fault <= r_skid_fault;
            end else begin
                r_out_vx    <= n_vx;
                r_out_vy    <= n_vy;
                r_out_fault <= n_fault;
            end
        end else if (w_new) begin
            r_skid_vx    <= n_vx;
            r_skid_vy    <= n_vy;
            r_skid_fault <= n_fault;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(lvm_pkg::OUT_W - 2*VW)'(0), r_out_vy, r_out_vx};
    assign o_m_tuser  = r_out_fault;

    // a held skid result always sits behind a held output result
    `LVM_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid without output")

    // a fault result carries zero velocities
    `LVM_ASSERT(a_fault_zero, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0), "fault with velocity")

    // the chain does not move while the skid register is full
    `LVM_ASSERT(a_chain_frozen, i_clk, i_rst_n, (r_skid_valid && $past(r_skid_valid)) |-> $stable(w_ctl[DW]), "chain moved while stalled")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for lattice_velocity_moment_core: cells stream in with
// random gaps while the output side stalls at random; every velocity result is
// predicted when its cell is accepted and checked field by field in order
// ----------------------------------------------------------------------------
module testbench;
    import lvm_pkg::*;

    // settle time before the verdict, plus margins for the run
    localparam int LATENCY        = FRAC_BITS_DEF + 19;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_CELLS    = 120;
    localparam int BURST_CELLS    = 120;

    localparam int  CELL_BITS = 8 * F_W + DEN_W + 2 * COORD_W;
    localparam longint VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 1;
    localparam longint VEL_MIN = -(64'sd1 <<< (VEL_W - 1));

    // register index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam logic [VEL_W-1:0]     LID_MOST_NEG = 17'h10000;
    localparam logic [VEL_W-1:0]     LID_MOST_POS = 17'h0FFFF;
    localparam logic [F_W-1:0]       F_FULL       = '1;
    localparam logic [DEN_W-1:0]     DEN_FULL     = '1;
    localparam int                   DEN_ONE      = 1 << FRAC_BITS_DEF;

    // one cell as it sits on the input bus, first field in the lowest bits
    typedef struct packed {
        logic [IN_W-CELL_BITS-1:0] pad;
        logic [COORD_W-1:0]        cell_y;
        logic [COORD_W-1:0]        cell_x;
        logic [DEN_W-1:0]          density;
        logic [F_W-1:0]            f_southeast;
        logic [F_W-1:0]            f_southwest;
        logic [F_W-1:0]            f_northwest;
        logic [F_W-1:0]            f_northeast;
        logic [F_W-1:0]            f_south;
        logic [F_W-1:0]            f_west;
        logic [F_W-1:0]            f_north;
        logic [F_W-1:0]            f_east;
    } t_cell;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    div_fault;
    } t_velocity;

    // ------------------------------------------------------------------------
    // clock, reset and the ports of the core
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [VEL_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    // f_east, f_north, f_west, f_south, f_northeast, f_northwest,
    // f_southwest, f_southeast (16 each), density (17), cell_x (10), cell_y (10)
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    // velocity_x (17), velocity_y (17)
    logic [OUT_W-1:0]     o_m_tdata;
    // divide_fault (1)
    logic                 o_m_tuser;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    lattice_velocity_moment_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // ------------------------------------------------------------------------
    // shadow of the registers as the core should hold them, reset values
    // ------------------------------------------------------------------------
    logic signed [VEL_W-1:0] lid_q         = LID_RST;
    logic [GRID_W-1:0]       grid_width_q  = GRID_RST;
    logic [GRID_W-1:0]       grid_height_q = GRID_RST;

    t_velocity pending_velocity[$];   // predicted results, oldest first
    int        mismatch_count = 0;

    // idling controls: the sender's is read only by the stimulus process
    bit tx_idle       = 1'b0;
    bit rx_idle       = 1'b0;
    int hold_requests = 0;

    // a grid size above the largest supported grid acts as the largest grid
    function automatic int effective_size(input logic [GRID_W-1:0] size);
        return (size > MAX_GRID_DEF) ? MAX_GRID_DEF : int'(size);
    endfunction

    // momentum over density, truncated toward zero, then clipped to the output
    function automatic logic signed [VEL_W-1:0] saturated_quotient(input longint num,
                                                                   input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag << FRAC_BITS_DEF) / den;
        if (num < 0)
            q = (q > -VEL_MIN) ? VEL_MIN : -q;
        else if (q > VEL_MAX)
            q = VEL_MAX;
        return q[VEL_W-1:0];
    endfunction

    function automatic t_velocity predict_velocity(input t_cell c);
        longint    w;
        longint    h;
        longint    x;
        longint    y;
        longint    mom_x;
        longint    mom_y;
        t_velocity r;
        r = '0;
        w = longint'(effective_size(grid_width_q));
        h = longint'(effective_size(grid_height_q));
        x = longint'(c.cell_x);
        y = longint'(c.cell_y);
        // cells outside the grid stay at rest with no fault
        if (x < w && y < h) begin
            if (x == 0 || x + 1 == w || y == 0) begin
                // side walls, bottom wall and every corner are at rest
            end else if (y + 1 == h) begin
                r.vel_x = lid_q;
            end else if (c.density == 0) begin
                r.div_fault = 1'b1;
            end else begin
                mom_x = longint'(c.f_east) + longint'(c.f_northeast)
                      + longint'(c.f_southeast) - longint'(c.f_west)
                      - longint'(c.f_northwest) - longint'(c.f_southwest);
                mom_y = longint'(c.f_north) + longint'(c.f_northeast)
                      + longint'(c.f_northwest) - longint'(c.f_south)
                      - longint'(c.f_southwest) - longint'(c.f_southeast);
                r.vel_x = saturated_quotient(mom_x, longint'(c.density));
                r.vel_y = saturated_quotient(mom_y, longint'(c.density));
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stalls per transaction, plus the long hold-off
    // ------------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin : result_receiver
        int draw;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // long hold-off: the pipe fills and the input side stalls
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (i_m_tready && o_m_tvalid) begin
                // a result was taken at this edge, draw the wait for the next one
                draw = rx_idle ? $urandom_range(0, 6) : 0;
                if (draw == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    stall_left = draw - 1;
                    i_m_tready <= 1'b0;
                end
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // every accepted result is held against the oldest prediction
    always @(posedge i_clk) begin : velocity_checker
        t_velocity want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_velocity.size() == 0) begin
                note_mismatch("unexpected transaction, velocity_x", 64'sd0,
                              longint'($signed(o_m_tdata[VEL_W-1:0])));
            end else begin
                want = pending_velocity.pop_front();
                if (o_m_tdata[VEL_W-1:0] !== want.vel_x)
                    note_mismatch("velocity_x", longint'(want.vel_x),
                                  longint'($signed(o_m_tdata[VEL_W-1:0])));
                if (o_m_tdata[2*VEL_W-1:VEL_W] !== want.vel_y)
                    note_mismatch("velocity_y", longint'(want.vel_y),
                                  longint'($signed(o_m_tdata[2*VEL_W-1:VEL_W])));
                if (o_m_tuser !== want.div_fault)
                    note_mismatch("divide_fault", longint'(want.div_fault),
                                  longint'(o_m_tuser));
            end
        end
    end

    // ends the run when no transaction moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_cell(input t_cell c);
        int gap;
        c.pad = '0;
        gap   = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        pending_velocity.push_back(predict_velocity(c));
    endtask

    // sender stops and waits until every predicted result has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_velocity.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VEL_W-1:0]     value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LID:    lid_q         = value;
            CFG_WIDTH:  grid_width_q  = value[GRID_W-1:0];
            CFG_HEIGHT: grid_height_q = value[GRID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input int width, input int height);
        write_register(CFG_WIDTH, VEL_W'(width));
        write_register(CFG_HEIGHT, VEL_W'(height));
    endtask

    task automatic set_idling(input bit tx, input bit rx);
        tx_idle = tx;
        rx_idle <= rx;
    endtask

    function automatic logic [F_W-1:0] random_population();
        if ($urandom_range(0, 3) == 0)
            return F_W'($urandom_range(0, 65535));
        return F_W'($urandom_range(0, DEN_ONE / 2));
    endfunction

    // a cell at rest: every moving population empty
    function automatic t_cell still_cell(input int x, input int y, input int dens);
        t_cell c;
        c         = '0;
        c.cell_x  = COORD_W'(x);
        c.cell_y  = COORD_W'(y);
        c.density = DEN_W'(dens);
        return c;
    endfunction

    function automatic t_cell make_cell(input int x, input int y, input int dens);
        t_cell c;
        c             = still_cell(x, y, dens);
        c.f_east      = random_population();
        c.f_north     = random_population();
        c.f_west      = random_population();
        c.f_south     = random_population();
        c.f_northeast = random_population();
        c.f_northwest = random_population();
        c.f_southwest = random_population();
        c.f_southeast = random_population();
        return c;
    endfunction

    // mostly interior cells of the current grid, some walls and strays
    function automatic t_cell random_cell();
        t_cell c;
        int    w;
        int    h;
        int    x;
        int    y;
        int    dens;
        int    kind;
        w = effective_size(grid_width_q);
        h = effective_size(grid_height_q);
        case ($urandom_range(0, 9))
            0:       dens = 0;
            1:       dens = $urandom_range(1, 64);
            2, 3:    dens = $urandom_range(0, DEN_FULL);
            default: dens = $urandom_range(DEN_ONE / 2, 2 * DEN_ONE);
        endcase
        x    = $urandom_range(0, MAX_GRID_DEF - 1);
        y    = $urandom_range(0, MAX_GRID_DEF - 1);
        kind = $urandom_range(0, 19);
        if (kind <= 12 && w >= 3 && h >= 3) begin
            x = $urandom_range(1, w - 2);
            y = $urandom_range(1, h - 2);
        end else if (kind <= 14 && w >= 1 && h >= 1) begin
            // top row, corners included
            x = $urandom_range(0, w - 1);
            y = h - 1;
        end else if (kind <= 16 && w >= 1 && h >= 1) begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
            case ($urandom_range(0, 2))
                0:       x = 0;
                1:       x = w - 1;
                default: y = 0;
            endcase
        end
        c = make_cell(x, y, dens);
        // now and then every population at full scale
        if ($urandom_range(0, 19) == 0)
            c[8*F_W-1:0] = '1;
        return c;
    endfunction

    function automatic int pick_grid_size();
        case ($urandom_range(0, 9))
            0:       return 3;
            1:       return MAX_GRID_DEF;
            2:       return $urandom_range(MAX_GRID_DEF + 1, (1 << GRID_W) - 1);
            3:       return $urandom_range(0, 2);
            4, 5, 6: return $urandom_range(3, 32);
            default: return $urandom_range(3, MAX_GRID_DEF);
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] pick_lid();
        case ($urandom_range(0, 4))
            0:       return LID_MOST_NEG;
            1:       return LID_MOST_POS;
            2:       return '0;
            default: return VEL_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // walls, corners, lid row, strays and the zero density fault, reset setup
    task automatic test_cell_classes();
        send_cell(make_cell(100, 100, DEN_ONE));
        send_cell(make_cell(100, 100, 0));
        send_cell(make_cell(128, 255, 0));
        send_cell(make_cell(0, 255, DEN_ONE));
        send_cell(make_cell(255, 255, DEN_ONE));
        send_cell(make_cell(0, 0, DEN_ONE));
        send_cell(make_cell(77, 0, DEN_ONE));
        send_cell(make_cell(255, 77, 0));
        send_cell(make_cell(256, 10, DEN_ONE));
        send_cell(make_cell(10, 256, DEN_ONE));
        send_cell(make_cell(MAX_GRID_DEF - 1, MAX_GRID_DEF - 1, int'(DEN_FULL)));
    endtask

    task automatic test_arithmetic_extremes();
        t_cell c;
        // strongest flow in each direction over the smallest density saturates
        c = still_cell(100, 100, 1);
        c.f_east = F_FULL; c.f_northeast = F_FULL; c.f_southeast = F_FULL;
        send_cell(c);
        c = still_cell(100, 100, 1);
        c.f_west = F_FULL; c.f_northwest = F_FULL; c.f_southwest = F_FULL;
        send_cell(c);
        c = still_cell(100, 100, 1);
        c.f_north = F_FULL; c.f_northeast = F_FULL; c.f_northwest = F_FULL;
        send_cell(c);
        c = still_cell(100, 100, 1);
        c.f_south = F_FULL; c.f_southwest = F_FULL; c.f_southeast = F_FULL;
        send_cell(c);
        // all populations full over the largest density, momentum cancels
        c = still_cell(100, 100, int'(DEN_FULL));
        c[8*F_W-1:0] = '1;
        send_cell(c);
        // unit density passes momentum straight through
        c = still_cell(50, 60, DEN_ONE);
        c.f_east = F_W'(DEN_ONE / 2);
        c.f_south = F_W'(DEN_ONE / 4);
        send_cell(c);
        // small negative ratio truncates toward zero
        c = still_cell(50, 60, 3);
        c.f_west = F_W'(1);
        c.f_north = F_W'(1);
        send_cell(c);
    endtask

    task automatic test_register_extremes();
        // smallest regular grid, lid at its most negative
        write_register(CFG_LID, LID_MOST_NEG);
        set_grid(3, 3);
        send_cell(make_cell(1, 1, DEN_ONE));
        send_cell(make_cell(1, 2, DEN_ONE));
        // largest grid, lid at its most positive
        write_register(CFG_LID, LID_MOST_POS);
        set_grid(MAX_GRID_DEF, MAX_GRID_DEF);
        send_cell(make_cell(MAX_GRID_DEF - 2, MAX_GRID_DEF - 1, DEN_ONE));
        send_cell(make_cell(MAX_GRID_DEF - 2, MAX_GRID_DEF - 2, DEN_ONE));
        // oversized grid acts as the largest one
        set_grid((1 << GRID_W) - 1, 1500);
        send_cell(make_cell(MAX_GRID_DEF - 1, 500, DEN_ONE));
        send_cell(make_cell(MAX_GRID_DEF - 2, MAX_GRID_DEF - 1, DEN_ONE));
        // tiny grids: walls take precedence over the lid row, the lid row over the fault
        set_grid(2, 2);
        send_cell(make_cell(1, 1, DEN_ONE));
        set_grid(3, 1);
        send_cell(make_cell(1, 0, DEN_ONE));
        set_grid(3, 2);
        send_cell(make_cell(1, 1, 0));
        // zero sized grid has no cells at all
        set_grid(0, 0);
        send_cell(make_cell(0, 0, 0));
        // the spare register index changes nothing
        write_register(CFG_UNUSED, VEL_W'($urandom));
        set_grid(3, 2);
        send_cell(make_cell(1, 1, DEN_ONE));
    endtask

    // output held off while the sender keeps streaming
    task automatic test_output_backpressure();
        write_register(CFG_LID, pick_lid());
        set_grid(64, 48);
        set_idling(1'b0, 1'b0);
        hold_requests <= hold_requests + 1;
        repeat (BURST_CELLS) send_cell(random_cell());
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [VEL_W-1:0] wd;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_register(CFG_LID, pick_lid());
            // upper write bits beyond the grid registers are don't care
            wd = VEL_W'($urandom);
            wd[GRID_W-1:0] = GRID_W'(pick_grid_size());
            write_register(CFG_WIDTH, wd);
            wd = VEL_W'($urandom);
            wd[GRID_W-1:0] = GRID_W'(pick_grid_size());
            write_register(CFG_HEIGHT, wd);
            set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            repeat (PHASE_CELLS) send_cell(random_cell());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(1'b1, 1'b1);
        test_cell_classes();
        test_arithmetic_extremes();
        test_register_extremes();
        test_output_backpressure();
        test_random_phases();
        // let any stray result surface before the verdict
        repeat (LATENCY + 16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_velocity.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
